FILE: hw/rtl/slmv_pkg.sv
// shared types and constants of the symmetric lower-storage matrix-vector block
`timescale 1ns / 1ps

package slmv_pkg;

    // request kinds, carried in the input tuser
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ENTRY   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_X       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_Y       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 3'd4;

    localparam int IDX_W       = 6;
    localparam int VAL_W       = 32;
    localparam int ACC_W       = 64;
    localparam int SIZE_W      = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

    // travels with every memory read of a compute
    typedef struct packed {
        logic             valid;
        logic             first;     // alpha*y term, opens a row
        logic             row_end;   // last product of the row
        logic             last_row;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

FILE: hw/rtl/slmv_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module slmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/slmv_seq.sv
// request decode, clearing sweep and address sequencer for the compute pass
`timescale 1ns / 1ps

module slmv_seq
    import slmv_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [IDX_W-1:0]     i_row,
    input  logic [IDX_W-1:0]     i_col,
    input  logic [VAL_W-1:0]     i_value,
    input  logic [SIZE_W-1:0]    i_active_size,
    input  logic                 i_stall,
    output logic                 o_re,
    output logic                 o_lo_we,
    output logic [$clog2(MAX_SIZE*(MAX_SIZE+1)/2)-1:0] o_lo_waddr,
    output logic [$clog2(MAX_SIZE*(MAX_SIZE+1)/2)-1:0] o_lo_raddr,
    output logic [VAL_W-1:0]     o_lo_wdata,
    output logic                 o_x_we,
    output logic                 o_y_we,
    output logic [$clog2(MAX_SIZE)-1:0] o_vec_waddr,
    output logic [VAL_W-1:0]     o_vec_wdata,
    output logic [$clog2(MAX_SIZE)-1:0] o_x_raddr,
    output logic [$clog2(MAX_SIZE)-1:0] o_y_raddr,
    output t_tag                 o_tag
);

    localparam int TRI_DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
    localparam int TW        = $clog2(TRI_DEPTH);
    localparam int XW        = $clog2(MAX_SIZE);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]    r_state;
    logic [TW-1:0] r_cnt;
    logic          r_clr_all;
    logic [XW-1:0] r_i;
    logic [XW-1:0] r_j;
    logic [XW-1:0] r_last;
    logic [TW-1:0] r_ptr;
    logic [TW-1:0] r_base;
    logic          r_yslot;
    t_tag          r_tag;

    logic          accept;
    logic          row_ok;
    logic          col_ok;
    logic          sweep_vec;
    logic [XW-1:0] n_last;
    logic [TW-1:0] n_base;
    logic [TW-1:0] n_ptr;
    t_tag          issue_tag;

    // packed lower-triangle address of (r, c), mirrored when r < c
    function automatic logic [11:0] tri_addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
        logic [12:0]      prod;
        hi   = (r < c) ? c : r;
        lo   = (r < c) ? r : c;
        prod = {7'd0, hi} * ({7'd0, hi} + 13'd1);
        return prod[12:1] + {6'd0, lo};
    endfunction

    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign row_ok    = ({1'b0, i_row} < SIZE_W'(MAX_SIZE));
    assign col_ok    = ({1'b0, i_col} < SIZE_W'(MAX_SIZE));
    assign sweep_vec = (r_state == ST_CLR) && r_clr_all && (r_cnt < TW'(MAX_SIZE));

    always_comb begin
        if (i_active_size == '0) begin
            n_last = '0;
        end else if (i_active_size > SIZE_W'(MAX_SIZE)) begin
            n_last = XW'(MAX_SIZE - 1);
        end else begin
            n_last = XW'(i_active_size - SIZE_W'(1));
        end
    end

    // entry (i, j) for j past the diagonal sits at tri(j) + i
    assign n_base = r_base + TW'(r_i) + TW'(1);
    assign n_ptr  = (r_j >= r_i) ? (r_ptr + TW'(r_j) + TW'(1)) : (r_ptr + TW'(1));

    // write side
    assign o_lo_we    = (r_state == ST_CLR)
                     || (accept && (i_action == ACT_ENTRY) && row_ok && col_ok);
    assign o_lo_waddr = (r_state == ST_CLR) ? r_cnt : TW'(tri_addr(i_row, i_col));
    assign o_lo_wdata = (r_state == ST_CLR) ? '0 : i_value;
    assign o_x_we     = sweep_vec || (accept && (i_action == ACT_X) && row_ok);
    assign o_y_we     = sweep_vec || (accept && (i_action == ACT_Y) && row_ok);
    assign o_vec_waddr = (r_state == ST_CLR) ? r_cnt[XW-1:0] : i_row[XW-1:0];
    assign o_vec_wdata = (r_state == ST_CLR) ? '0 : i_value;

    // read side
    assign o_re       = !i_stall;
    assign o_lo_raddr = r_ptr;
    assign o_x_raddr  = r_j;
    assign o_y_raddr  = r_i;

    always_comb begin
        issue_tag.valid    = (r_state == ST_RUN);
        issue_tag.first    = r_yslot;
        issue_tag.row_end  = !r_yslot && (r_j == r_last);
        issue_tag.last_row = (r_i == r_last);
        issue_tag.idx      = IDX_W'(r_i);
    end

    assign o_tag = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_cnt     <= '0;
            r_clr_all <= 1'b1;
            r_tag     <= '0;
        end else begin
            if (!i_stall) begin
                r_tag <= issue_tag;
            end
            unique case (r_state)
                ST_CLR: begin
                    if (r_cnt == TW'(TRI_DEPTH - 1)) begin
                        r_state   <= ST_IDLE;
                        r_clr_all <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (i_action == ACT_CLEAR) begin
                            r_state   <= ST_CLR;
                            r_cnt     <= '0;
                            r_clr_all <= 1'b0;
                        end else if (i_action == ACT_COMPUTE) begin
                            r_state <= ST_RUN;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_ptr   <= '0;
                            r_base  <= '0;
                            r_yslot <= 1'b1;
                            r_last  <= n_last;
                        end
                    end
                end
                ST_RUN: begin
                    if (!i_stall) begin
                        if (r_yslot) begin
                            r_yslot <= 1'b0;
                        end else if (r_j == r_last) begin
                            if (r_i == r_last) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_i     <= r_i + XW'(1);
                                r_j     <= '0;
                                r_base  <= n_base;
                                r_ptr   <= n_base;
                                r_yslot <= 1'b1;
                            end
                        end else begin
                            r_ptr <= n_ptr;
                            r_j   <= r_j + XW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/slmv_mac.sv
// multiply, saturating accumulate, clamp and result register
`timescale 1ns / 1ps

module slmv_mac
    import slmv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tag             i_tag,
    input  logic [VAL_W-1:0] i_lo_rdata,
    input  logic [VAL_W-1:0] i_x_rdata,
    input  logic [VAL_W-1:0] i_y_rdata,
    input  logic [VAL_W-1:0] i_alpha,
    input  logic             i_ready,
    output logic             o_stall,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_index,
    output logic [VAL_W-1:0] o_value,
    output logic             o_sat,
    output logic             o_last
);

    t_tag                    r_tag;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_index;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_sat;
    logic                    r_out_last;

    logic signed [VAL_W-1:0] op_a;
    logic signed [VAL_W-1:0] op_b;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] sum;
    logic                    ovf;
    logic signed [ACC_W-1:0] n_acc;
    logic                    clamp_hi;
    logic                    clamp_lo;
    logic                    load;

    assign op_a = i_tag.first ? $signed(i_alpha)   : $signed(i_lo_rdata);
    assign op_b = i_tag.first ? $signed(i_y_rdata) : $signed(i_x_rdata);
    assign prod = ACC_W'(op_a) * ACC_W'(op_b);

    // arithmetic shift is the floor of the scaled product
    assign term = r_prod >>> FRAC_BITS;
    assign sum  = r_acc + term;
    assign ovf  = (r_acc[ACC_W-1] == term[ACC_W-1]) && (sum[ACC_W-1] != r_acc[ACC_W-1]);

    always_comb begin
        if (r_tag.first) begin
            n_acc = term;
        end else if (ovf) begin
            n_acc = term[ACC_W-1] ? $signed(ACC_MIN) : $signed(ACC_MAX);
        end else begin
            n_acc = sum;
        end
    end

    assign clamp_hi = !n_acc[ACC_W-1] && (n_acc[ACC_W-2:VAL_W-1] != '0);
    assign clamp_lo =  n_acc[ACC_W-1] && (n_acc[ACC_W-2:VAL_W-1] != '1);

    // hold everything while a finished row waits behind an unread result
    assign o_stall = r_out_valid && !i_ready && r_tag.valid && r_tag.row_end;
    assign load    = !o_stall && r_tag.valid && r_tag.row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_tag  <= i_tag;
                r_prod <= prod;
                if (r_tag.valid) begin
                    r_acc <= n_acc;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_out_index <= r_tag.idx;
                r_out_last  <= r_tag.last_row;
                r_out_sat   <= clamp_hi || clamp_lo;
                if (clamp_hi) begin
                    r_out_value <= VAL_MAX;
                end else if (clamp_lo) begin
                    r_out_value <= VAL_MIN;
                end else begin
                    r_out_value <= n_acc[VAL_W-1:0];
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_index = r_out_index;
    assign o_value = r_out_value;
    assign o_sat   = r_out_sat;
    assign o_last  = r_out_last;

endmodule

FILE: hw/rtl/symmetric_lower_matvec.sv
// top level: symmetric matrix-vector multiply with lower-triangle storage
// load requests (entry, x, y) may follow back to back
// compute reads the memories row by row, one row of n+1 reads per result,
// n = active size (1 for size 0, at most MAX_SIZE); an unread result stalls the
// reads once the next row is done; every result comes from the single
// multiply-accumulate path behind the three memories
// after reset and after a clear request a sweep zeroes all MAX_SIZE*(MAX_SIZE+1)/2
// matrix entries (after reset also x and y); no request is taken meanwhile
`timescale 1ns / 1ps

module symmetric_lower_matvec
    import slmv_pkg::*;
#(
    parameter int MAX_SIZE  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row[5:0], col[11:6], value[43:12]
    input  logic [ACT_W-1:0]       s_axis_tuser,   // action[2:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_index[5:0], out_value[37:6]
    output logic                   m_axis_tuser,   // saturated[0]
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int TRI_DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
    localparam int TW        = $clog2(TRI_DEPTH);
    localparam int XW        = $clog2(MAX_SIZE);

    logic [SIZE_W-1:0] r_active_size;
    logic [VAL_W-1:0]  r_alpha;

    logic              stall;
    logic              re;
    logic              lo_we;
    logic [TW-1:0]     lo_waddr;
    logic [TW-1:0]     lo_raddr;
    logic [VAL_W-1:0]  lo_wdata;
    logic [VAL_W-1:0]  lo_rdata;
    logic              x_we;
    logic              y_we;
    logic [XW-1:0]     vec_waddr;
    logic [VAL_W-1:0]  vec_wdata;
    logic [XW-1:0]     x_raddr;
    logic [XW-1:0]     y_raddr;
    logic [VAL_W-1:0]  x_rdata;
    logic [VAL_W-1:0]  y_rdata;
    t_tag              tag;
    logic [IDX_W-1:0]  out_index;
    logic [VAL_W-1:0]  out_value;

    // register file: active_size at 0, alpha at 4
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= SIZE_W'(64);
            r_alpha       <= 32'h0001_0000;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_alpha <= pwdata;
            end else begin
                r_active_size <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = !psel     ? 32'd0
                  : paddr[2]  ? r_alpha
                  :             {{(32-SIZE_W){1'b0}}, r_active_size};

    slmv_seq #(
        .MAX_SIZE (MAX_SIZE)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_row         (s_axis_tdata[5:0]),
        .i_col         (s_axis_tdata[11:6]),
        .i_value       (s_axis_tdata[43:12]),
        .i_active_size (r_active_size),
        .i_stall       (stall),
        .o_re          (re),
        .o_lo_we       (lo_we),
        .o_lo_waddr    (lo_waddr),
        .o_lo_raddr    (lo_raddr),
        .o_lo_wdata    (lo_wdata),
        .o_x_we        (x_we),
        .o_y_we        (y_we),
        .o_vec_waddr   (vec_waddr),
        .o_vec_wdata   (vec_wdata),
        .o_x_raddr     (x_raddr),
        .o_y_raddr     (y_raddr),
        .o_tag         (tag)
    );

    slmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TRI_DEPTH)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (lo_we),
        .i_waddr (lo_waddr),
        .i_wdata (lo_wdata),
        .i_re    (re),
        .i_raddr (lo_raddr),
        .o_rdata (lo_rdata)
    );

    slmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SIZE)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (vec_waddr),
        .i_wdata (vec_wdata),
        .i_re    (re),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    slmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SIZE)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (vec_waddr),
        .i_wdata (vec_wdata),
        .i_re    (re),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    slmv_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (tag),
        .i_lo_rdata (lo_rdata),
        .i_x_rdata  (x_rdata),
        .i_y_rdata  (y_rdata),
        .i_alpha    (r_alpha),
        .i_ready    (m_axis_tready),
        .o_stall    (stall),
        .o_valid    (m_axis_tvalid),
        .o_index    (out_index),
        .o_value    (out_value),
        .o_sat      (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_value, out_index};

endmodule

FILE: hw/rtl/slmv_chk.sv
// port-level checks of the matrix-vector block and their binding
`timescale 1ns / 1ps

module slmv_chk
    import slmv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [ACT_W-1:0]       s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   m_axis_tlast
);

    // a result not taken stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // clearing sweep follows reset, no request taken
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request taken during reset sweep");

    // a compute request keeps the input side busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_COMPUTE) |=> !s_axis_tready)
        else $error("request taken right after compute");

    // a flagged result sits at one of the clamp bounds
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[37:6] == VAL_MAX) || (m_axis_tdata[37:6] == VAL_MIN))
        else $error("saturated flag without clamped value");

endmodule

bind symmetric_lower_matvec slmv_chk u_slmv_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
